### rtl/core/text_console_scroll_writer_defines.svh
// Assertion macros shared by the console writer checker.
`ifndef TEXT_CONSOLE_SCROLL_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_SCROLL_WRITER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define TCSW_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("console writer check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define TCSW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("console writer check failed");

`endif

### rtl/core/tcsw_pkg.sv
// ----------------------------------------------------------------------------
// Text console scroll writer package
// Geometry, field widths, item layouts and mode codes shared by the core.
// ----------------------------------------------------------------------------
`default_nettype none

package tcsw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;

    localparam int RowW    = 5;
    localparam int ColW    = 7;
    localparam int CodeW   = 8;
    localparam int CellW   = 16;
    localparam int MarginW = 5;
    localparam int AddrW   = $clog2(CELLS);
    localparam int CfgIdxW = 1;

    localparam logic [CodeW-1:0]   NEWLINE_CODE = 8'd10;
    localparam logic [CfgIdxW-1:0] CFG_TOP      = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_BOTTOM   = 1'b1;

    typedef enum logic [1:0] {
        MODE_PRINT = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_READ  = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode             mode;
        logic [CodeW-1:0]  char_code;
        logic [CodeW-1:0]  color;
        logic [RowW-1:0]   row;
        logic [ColW-1:0]   column;
    } t_item;

    typedef struct packed {
        logic [MarginW-1:0] top_margin_rows;
        logic [MarginW-1:0] bottom_margin_rows;
    } t_cfg;

    typedef struct packed {
        logic              scrolled;
        logic [CellW-1:0]  cell_data;
        logic [ColW-1:0]   cursor_column;
        logic [RowW-1:0]   cursor_row;
    } t_result;

    function automatic logic [AddrW-1:0] cell_addr(input logic [RowW-1:0] row,
                                                   input logic [ColW-1:0] col);
        return AddrW'(row) * AddrW'(COLUMNS) + AddrW'(col);
    endfunction

endpackage

`default_nettype wire

### rtl/core/text_console_scroll_writer.sv
// An ordinary item (print without scroll, cell write, cell read) goes from
// S_IDLE to S_DONE, where its result waits until the output register can take
// it; the block accepts no new item before that result is handed on. A print
// that scrolls walks the cell RAM through its one read and one write port:
// it moves (last usable row - top margin) * 80 cells, passes a drain state
// when rows move, blanks the 80 cells of the last usable row and then places
// the character. After reset the block clears all 2000 cells, one per cycle,
// and accepts no item until that clearing pass ends; configuration writes are
// taken at any time. The output register lets a new item be accepted while
// the previous result waits to be taken.
// ----------------------------------------------------------------------------
// Text console scroll writer
// Stream-facing top level with margin registers and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_scroll_writer (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [tcsw_pkg::CfgIdxW-1:0] i_cfg_index,
    input  wire logic [tcsw_pkg::MarginW-1:0] i_cfg_wdata,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: char_code[7:0], color[15:8], row[20:16], column[27:21], zero[31:28]
    input  wire logic [31:0]                  s_axis_tdata,
    // tuser: mode[1:0]
    input  wire logic [1:0]                   s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // tdata: cursor_row[4:0], cursor_column[11:5], cell_data[27:12],
    //        scrolled[28], zero[31:29]
    output logic      [31:0]                  m_axis_tdata
);

    import tcsw_pkg::*;

    t_cfg    r_cfg;
    t_item   in_item;
    t_result result;
    t_result r_out;
    logic    r_out_valid;
    logic    res_valid;
    logic    res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.top_margin_rows    <= MarginW'(0);
            r_cfg.bottom_margin_rows <= MarginW'(5);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TOP:    r_cfg.top_margin_rows    <= i_cfg_wdata;
                CFG_BOTTOM: r_cfg.bottom_margin_rows <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign in_item.mode      = t_mode'(s_axis_tuser);
    assign in_item.char_code = s_axis_tdata[7:0];
    assign in_item.color     = s_axis_tdata[15:8];
    assign in_item.row       = s_axis_tdata[20:16];
    assign in_item.column    = s_axis_tdata[27:21];

    assign res_ready = !r_out_valid || m_axis_tready;

    tcsw_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_item   (in_item),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
            if (res_valid) begin
                r_out <= result;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out};

endmodule

`default_nettype wire

### rtl/core/tcsw_ram.sv
// ----------------------------------------------------------------------------
// Text console cell RAM
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tcsw_ram #(
    parameter int DEPTH = 2000,
    parameter int WIDTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/core/tcsw_seq.sv
// ----------------------------------------------------------------------------
// Text console sequencer
// Holds the cursor, decodes items and drives the cell RAM, including the
// power-up clearing pass and the row-copy walk of a scroll.
// ----------------------------------------------------------------------------
`default_nettype none

module tcsw_seq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tcsw_pkg::t_cfg    i_cfg,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire tcsw_pkg::t_item   i_in_item,
    output logic                   o_res_valid,
    input  wire logic              i_res_ready,
    output tcsw_pkg::t_result      o_result
);

    import tcsw_pkg::*;

    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_MOVE, S_DRAIN, S_CLEAR, S_PUT, S_DONE
    } t_state;

    t_state           r_state;
    t_item            r_item;
    logic [RowW-1:0]  r_cur_row;
    logic [ColW-1:0]  r_cur_col;
    logic [AddrW-1:0] r_addr;
    logic [AddrW-1:0] r_end;
    logic             r_pend;
    logic [AddrW-1:0] r_pend_addr;
    logic             r_scrolled;
    logic             r_rd_hit;

    logic [RowW-1:0]  last_row;
    logic             need_scroll;
    logic             do_move;
    logic             accept;
    logic             in_range;
    logic             put_char;
    t_item            act_item;

    logic             we;
    logic [AddrW-1:0] waddr;
    logic [CellW-1:0] wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
    logic [CellW-1:0] rdata;

    always_comb begin
        if (i_cfg.bottom_margin_rows >= MarginW'(ROWS)) begin
            last_row = '0;
        end else begin
            last_row = RowW'(ROWS - 1) - RowW'(i_cfg.bottom_margin_rows);
        end
    end

    assign need_scroll = r_cur_row > last_row;
    assign do_move     = RowW'(i_cfg.top_margin_rows) < last_row;
    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign in_range    = (i_in_item.row < RowW'(ROWS)) && (i_in_item.column < ColW'(COLUMNS));
    assign act_item    = (r_state == S_PUT) ? r_item : i_in_item;
    assign put_char    = (r_state == S_PUT) ||
                         (accept && (i_in_item.mode == MODE_PRINT) &&
                          (i_in_item.char_code != '0) && !need_scroll);

    always_comb begin
        we    = 1'b0;
        waddr = r_addr;
        wdata = '0;
        if (r_pend) begin
            we    = 1'b1;
            waddr = r_pend_addr;
            wdata = rdata;
        end else if (r_state == S_INIT || r_state == S_CLEAR) begin
            we = 1'b1;
        end else if (put_char) begin
            we    = (act_item.char_code != NEWLINE_CODE);
            waddr = cell_addr(r_cur_row, r_cur_col);
            wdata = {act_item.color, act_item.char_code};
        end else if (accept && i_in_item.mode == MODE_WRITE) begin
            we    = in_range;
            waddr = cell_addr(i_in_item.row, i_in_item.column);
            wdata = {i_in_item.color, i_in_item.char_code};
        end
    end

    always_comb begin
        if (r_state == S_MOVE) begin
            re    = 1'b1;
            raddr = r_addr;
        end else begin
            re    = accept && (i_in_item.mode == MODE_READ) && in_range;
            raddr = cell_addr(i_in_item.row, i_in_item.column);
        end
    end

    tcsw_ram #(
        .DEPTH (CELLS),
        .WIDTH (CellW),
        .AW    (AddrW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_addr     <= '0;
            r_end      <= '0;
            r_pend     <= 1'b0;
            r_cur_row  <= '0;
            r_cur_col  <= '0;
            r_scrolled <= 1'b0;
            r_rd_hit   <= 1'b0;
        end else begin
            r_pend <= (r_state == S_MOVE);
            if (put_char) begin
                if (act_item.char_code == NEWLINE_CODE ||
                    r_cur_col == ColW'(COLUMNS - 1)) begin
                    r_cur_row <= r_cur_row + 1'b1;
                    r_cur_col <= '0;
                end else begin
                    r_cur_col <= r_cur_col + 1'b1;
                end
            end
            unique case (r_state)
                S_INIT: begin
                    if (r_addr == AddrW'(CELLS - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_item     <= i_in_item;
                        r_rd_hit   <= (i_in_item.mode == MODE_READ) && in_range;
                        if (i_in_item.mode == MODE_PRINT && i_in_item.char_code != '0 &&
                            need_scroll) begin
                            r_scrolled <= 1'b1;
                            if (do_move) begin
                                r_addr  <= cell_addr(RowW'(i_cfg.top_margin_rows) + 1'b1, '0);
                                r_end   <= cell_addr(last_row, ColW'(COLUMNS - 1));
                                r_state <= S_MOVE;
                            end else begin
                                r_addr  <= cell_addr(last_row, '0);
                                r_end   <= cell_addr(last_row, ColW'(COLUMNS - 1));
                                r_state <= S_CLEAR;
                            end
                        end else begin
                            r_scrolled <= 1'b0;
                            r_state    <= S_DONE;
                        end
                    end
                end
                S_MOVE: begin
                    r_pend_addr <= r_addr - AddrW'(COLUMNS);
                    if (r_addr == r_end) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_DRAIN: begin
                    r_addr  <= cell_addr(last_row, '0);
                    r_end   <= cell_addr(last_row, ColW'(COLUMNS - 1));
                    r_state <= S_CLEAR;
                end
                S_CLEAR: begin
                    if (r_addr == r_end) begin
                        r_cur_row <= last_row;
                        r_cur_col <= '0;
                        r_state   <= S_PUT;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_PUT: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res_valid             = (r_state == S_DONE);
    assign o_result.cursor_row     = r_cur_row;
    assign o_result.cursor_column  = r_cur_col;
    assign o_result.cell_data      = r_rd_hit ? rdata : '0;
    assign o_result.scrolled       = r_scrolled;

endmodule

`default_nettype wire

### rtl/core/tcsw_checker.sv
// ----------------------------------------------------------------------------
// Text console scroll writer checker
// Port-level checks on the console writer, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_console_scroll_writer_defines.svh"

module tcsw_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_cfg_we,
    input wire logic [0:0]  i_cfg_index,
    input wire logic [4:0]  i_cfg_wdata,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [31:0] s_axis_tdata,
    input wire logic [1:0]  s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata
);

    // A waiting result item keeps its value until it is taken.
    `TCSW_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // The cell store is being cleared in the first cycle after reset.
    `TCSW_ASSERT_NOW(a_init_busy, $past(!i_rst_n), !s_axis_tready)

    // The reported cursor column always lies on the screen.
    `TCSW_ASSERT_NOW(a_col_range, m_axis_tvalid, m_axis_tdata[11:5] < 7'd80)

    // After a scroll the cursor sits at the start of a row or one cell past it.
    `TCSW_ASSERT_NOW(a_scroll_col, m_axis_tvalid && m_axis_tdata[28], m_axis_tdata[11:5] < 7'd2)

endmodule

bind text_console_scroll_writer tcsw_checker u_tcsw_checker (.*);

`default_nettype wire
